@@ rtl/spc_pkg.sv @@
`timescale 1ns / 1ps

package spc_pkg;

	localparam int IN_POS_W = 24;
	localparam int RAD_W    = 20;
	localparam int MASK_W   = 32;
	localparam int IDX_W    = 5;
	localparam int RS_W     = RAD_W + 1;
	localparam int RS2_W    = 2 * RS_W;

	// one slot of the scan pipeline: a stored entry to test, or the end marker
	typedef struct packed {
		logic             v;
		logic             fin;
		logic [IDX_W-1:0] idx;
	} token_t;

	typedef struct packed {
		logic hs;	// stored sprite is struck by the arrival
		logic hn;	// arrival is struck by the stored sprite
	} hit_t;

endpackage

@@ rtl/spc_dist.sv @@
`timescale 1ns / 1ps

module spc_dist import spc_pkg::*; #(
	parameter int POS_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  token_t                     tok_s1,
	input  logic signed [POS_BITS-1:0] st_x,
	input  logic signed [POS_BITS-1:0] st_y,
	input  logic signed [POS_BITS-1:0] st_z,
	input  logic [RAD_W-1:0]           st_rad,
	input  logic [MASK_W-1:0]          st_def,
	input  logic [MASK_W-1:0]          st_att,
	input  logic                       st_act,
	input  logic signed [POS_BITS-1:0] ar_x,
	input  logic signed [POS_BITS-1:0] ar_y,
	input  logic signed [POS_BITS-1:0] ar_z,
	input  logic [RAD_W-1:0]           ar_rad,
	input  logic [MASK_W-1:0]          ar_def,
	input  logic [MASK_W-1:0]          ar_att,
	output token_t                     tok_s4,
	output hit_t                       hit_s4
);

	localparam int DW  = POS_BITS + 1;
	localparam int SQW = 2 * DW;
	localparam int SW  = SQW + 2;
	localparam int CW  = (SW > RS2_W) ? SW : RS2_W;

	logic signed [DW-1:0] dx, dy, dz;
	logic [DW-1:0]        mx, my, mz;

	token_t            tok_s2, tok_s3;
	hit_t              hit_s2, hit_s3;
	logic [DW-1:0]     mx_s2, my_s2, mz_s2;
	logic [RS_W-1:0]   rs_s2;
	logic [SQW-1:0]    sqx_s3, sqy_s3, sqz_s3;
	logic [RS2_W-1:0]  rs2_s3;
	logic [CW-1:0]     d2, r2;
	logic              near;

	assign dx = {st_x[POS_BITS-1], st_x} - {ar_x[POS_BITS-1], ar_x};
	assign dy = {st_y[POS_BITS-1], st_y} - {ar_y[POS_BITS-1], ar_y};
	assign dz = {st_z[POS_BITS-1], st_z} - {ar_z[POS_BITS-1], ar_z};
	assign mx = dx[DW-1] ? DW'(~dx + 1'b1) : DW'(dx);
	assign my = dy[DW-1] ? DW'(~dy + 1'b1) : DW'(dy);
	assign mz = dz[DW-1] ? DW'(~dz + 1'b1) : DW'(dz);

	assign d2   = CW'(sqx_s3) + CW'(sqy_s3) + CW'(sqz_s3);
	assign r2   = CW'(rs2_s3);
	assign near = d2 < r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
			tok_s3 <= '0;
			tok_s4 <= '0;
		end else if (adv) begin
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
			tok_s4 <= tok_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s2     <= mx;
			my_s2     <= my;
			mz_s2     <= mz;
			rs_s2     <= RS_W'(st_rad) + RS_W'(ar_rad);
			hit_s2.hs <= st_act & (|(st_def & ar_att));
			hit_s2.hn <= st_act & (|(ar_def & st_att));

			sqx_s3    <= mx_s2 * mx_s2;
			sqy_s3    <= my_s2 * my_s2;
			sqz_s3    <= mz_s2 * mz_s2;
			rs2_s3    <= rs_s2 * rs_s2;
			hit_s3    <= hit_s2;

			hit_s4.hs <= hit_s3.hs & near;
			hit_s4.hn <= hit_s3.hn & near;
		end
	end

endmodule

@@ rtl/sphere_pair_collision_masked_top.sv @@
`timescale 1ns / 1ps
// Events of a beat go through the store read, stages s2 to s4, the held event and the output.
// A new beat waits until the scan of the last is done; the scan tests n stored entries,
//   n = sprites stored ahead of an active arrival with room (up to MAX_SPRITES - 1), else 0.
// Each entry is read once; a pair that strikes both ways, or output stall, holds the scan.
// Reset clears the sprite count, the scan control and the output valid; store contents
//   stay undefined and are never used before written.
module sphere_pair_collision_masked_top import spc_pkg::*; #(
	parameter int MAX_SPRITES = 32,
	parameter int POS_BITS    = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [IN_POS_W-1:0] pos_x,
	input  logic signed [IN_POS_W-1:0] pos_y,
	input  logic signed [IN_POS_W-1:0] pos_z,
	input  logic [RAD_W-1:0]           radius,
	input  logic [MASK_W-1:0]          defend_mask,
	input  logic [MASK_W-1:0]          attack_mask,
	input  logic                       active,
	input  logic                       last_of_set,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [IDX_W-1:0]           struck_index,
	output logic [IDX_W-1:0]           striker_index,
	output logic                       event_last
);

	localparam int IDXW = $clog2(MAX_SPRITES);
	localparam int CNTW = $clog2(MAX_SPRITES + 1);
	localparam int EW   = 3 * POS_BITS + RAD_W + 2 * MASK_W + 1;

	logic [EW-1:0] mem [MAX_SPRITES];

	logic                accept, has_room;
	logic                busy_q, issued_q;
	logic [CNTW-1:0]     count_q, j_q, n_q;
	logic [IDX_W-1:0]    me_q;
	logic                issue_v;
	logic                adv;

	logic signed [POS_BITS-1:0] ar_x_q, ar_y_q, ar_z_q;
	logic [RAD_W-1:0]           ar_rad_q;
	logic [MASK_W-1:0]          ar_def_q, ar_att_q;

	token_t        tok_s1, tok_s4;
	hit_t          hit_s4;
	logic [EW-1:0] rd_s1;

	logic signed [POS_BITS-1:0] rd_x, rd_y, rd_z;
	logic [RAD_W-1:0]           rd_rad;
	logic [MASK_W-1:0]          rd_def, rd_att;
	logic                       rd_act;

	logic             second_q;
	logic             pend_v_q;
	logic [IDX_W-1:0] pend_struck_q, pend_striker_q;
	logic             out_v_q, out_last_q;
	logic [IDX_W-1:0] out_struck_q, out_striker_q;

	logic             out_free, can_take, cand_a, cand_b, cand, take, fin_tok, fin_done;
	logic             push_out;
	logic [IDX_W-1:0] cand_struck, cand_striker;

	assign in_stall = busy_q;
	assign accept   = in_valid & ~busy_q;
	assign has_room = count_q < CNTW'(MAX_SPRITES);

	// store write: the arrival goes to its own slot, read by the scan at most for the end marker
	always_ff @(posedge clk) begin
		if (accept && has_room) begin
			mem[count_q[IDXW-1:0]] <= {pos_x[POS_BITS-1:0], pos_y[POS_BITS-1:0],
				pos_z[POS_BITS-1:0], radius, defend_mask, attack_mask, active};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= mem[j_q[IDXW-1:0]];
		end
	end

	assign {rd_x, rd_y, rd_z, rd_rad, rd_def, rd_att, rd_act} = rd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			ar_x_q   <= pos_x[POS_BITS-1:0];
			ar_y_q   <= pos_y[POS_BITS-1:0];
			ar_z_q   <= pos_z[POS_BITS-1:0];
			ar_rad_q <= radius;
			ar_def_q <= defend_mask;
			ar_att_q <= attack_mask;
			me_q     <= IDX_W'(count_q);
		end
	end

	assign issue_v = busy_q & ~issued_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			issued_q <= 1'b0;
			count_q  <= '0;
			j_q      <= '0;
			n_q      <= '0;
			tok_s1   <= '0;
		end else begin
			if (accept) begin
				busy_q   <= 1'b1;
				issued_q <= 1'b0;
				j_q      <= '0;
				n_q      <= (active && has_room) ? count_q : '0;
				if (last_of_set) begin
					count_q <= '0;
				end else if (has_room) begin
					count_q <= count_q + 1'b1;
				end
			end else if (fin_done) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				tok_s1.v   <= issue_v;
				tok_s1.fin <= j_q == n_q;
				tok_s1.idx <= IDX_W'(j_q);
				if (issue_v) begin
					if (j_q == n_q) begin
						issued_q <= 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
			end
		end
	end

	spc_dist #(
		.POS_BITS(POS_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tok_s1 (tok_s1),
		.st_x   (rd_x),
		.st_y   (rd_y),
		.st_z   (rd_z),
		.st_rad (rd_rad),
		.st_def (rd_def),
		.st_att (rd_att),
		.st_act (rd_act),
		.ar_x   (ar_x_q),
		.ar_y   (ar_y_q),
		.ar_z   (ar_z_q),
		.ar_rad (ar_rad_q),
		.ar_def (ar_def_q),
		.ar_att (ar_att_q),
		.tok_s4 (tok_s4),
		.hit_s4 (hit_s4)
	);

	// one event is held back so the final one of an item can carry event_last
	always_comb begin
		out_free     = ~out_v_q | ~out_stall;
		can_take     = ~pend_v_q | out_free;
		cand_a       = tok_s4.v & ~tok_s4.fin & hit_s4.hs & ~second_q;
		cand_b       = tok_s4.v & ~tok_s4.fin & hit_s4.hn & ~cand_a;
		cand         = cand_a | cand_b;
		take         = cand & can_take;
		fin_tok      = tok_s4.v & tok_s4.fin;
		fin_done     = fin_tok & (~pend_v_q | out_free);
		push_out     = pend_v_q & (take | fin_done);
		cand_struck  = cand_a ? tok_s4.idx : me_q;
		cand_striker = cand_a ? me_q : tok_s4.idx;
		if (!tok_s4.v) begin
			adv = 1'b1;
		end else if (fin_tok) begin
			adv = fin_done;
		end else begin
			adv = ~cand | (take & ~(cand_a & hit_s4.hn));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (adv) begin
				second_q <= 1'b0;
			end else if (take && cand_a) begin
				second_q <= 1'b1;
			end
			if (take) begin
				pend_v_q <= 1'b1;
			end else if (fin_done) begin
				pend_v_q <= 1'b0;
			end
			if (push_out) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_struck_q  <= cand_struck;
			pend_striker_q <= cand_striker;
		end
		if (push_out) begin
			out_struck_q  <= pend_struck_q;
			out_striker_q <= pend_striker_q;
			out_last_q    <= fin_tok;
		end
	end

	assign out_valid     = out_v_q;
	assign struck_index  = out_struck_q;
	assign striker_index = out_striker_q;
	assign event_last    = out_last_q;

	a_pair_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> struck_index != striker_index)
		else $error("event names the same sprite twice");

	a_second_holds: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (tok_s4.v && hit_s4.hs && hit_s4.hn))
		else $error("second half of a two-way hit lost its entry");

	a_drain_clean: assert property (@(posedge clk) disable iff (!arst_n)
		fin_done |=> (!pend_v_q && !busy_q))
		else $error("held event left behind after item end");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_SPRITES))
		else $error("sprite count beyond capacity");

endmodule
